@@ hdl/kchd_pkg.sv @@
// Package for the key click / hold / multi-click detector.
// Holds the key mode encoding, register indexes and reset defaults.
// No dependencies.
package kchd_pkg;

    // Default sizing handed to the top level.
    localparam int KEYS_DEFAULT      = 4;
    localparam int TIME_BITS_DEFAULT = 16;

    // Widths of the configuration port and the threshold registers.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int STEP_BITS      = 8;
    localparam int THRESH_BITS    = 16;

    // Register values after reset.
    localparam logic [STEP_BITS-1:0]   TICK_STEP_RESET     = 8'd3;
    localparam logic [THRESH_BITS-1:0] PRESS_THRESH_RESET  = 16'd30;
    localparam logic [THRESH_BITS-1:0] HOLD_THRESH_RESET   = 16'd900;
    localparam logic [THRESH_BITS-1:0] INTERVAL_THRESH_RESET = 16'd300;

    // Per-key mode of the click machine.
    typedef enum logic [2:0] {
        MODE_RELEASE  = 3'd0,
        MODE_DITHER   = 3'd1,
        MODE_PRECLICK = 3'd2,
        MODE_INCLICK  = 3'd3,
        MODE_PRESS    = 3'd4,
        MODE_HOLD     = 3'd5,
        MODE_MULTI    = 3'd6
    } t_key_mode;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TICK_STEP       = 2'd0,
        REG_PRESS_THRESH    = 2'd1,
        REG_HOLD_THRESH     = 2'd2,
        REG_INTERVAL_THRESH = 2'd3
    } t_cfg_reg;

endpackage

@@ hdl/key_click_hold_multi_detector_unit.sv @@
// A scan beat accepted while the output register is free or being taken shows its flags
// at o_valid in the next cycle, else it waits in the skid stage first. One scan beat per
// cycle while not stalled; key updates are short logic from state to output registers.
// Reset (i_rst_n low, synchronous): all keys in release, timers and flags cleared,
// registers back to their defaults, output and skid stage empty; no beat is taken
// while reset is held.
//
// Top level of the key click / hold / multi-click detector. Depends on kchd_pkg.
module key_click_hold_multi_detector_unit
    import kchd_pkg::*;
#(
    parameter int KEYS      = KEYS_DEFAULT,
    parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Scan beat input
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [KEYS-1:0]           i_keys_pressed,
    // Flag beat output
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [KEYS-1:0]           o_press_flags,
    output logic [KEYS-1:0]           o_hold_flags,
    output logic [KEYS-1:0]           o_multi_flags,
    // Configuration writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int CMP_BITS = (TIME_BITS > THRESH_BITS) ? TIME_BITS : THRESH_BITS;

    // Configuration registers
    logic [STEP_BITS-1:0]   r_tick_step;
    logic [THRESH_BITS-1:0] r_press_thresh;
    logic [THRESH_BITS-1:0] r_hold_thresh;
    logic [THRESH_BITS-1:0] r_interval_thresh;

    // Per-key state
    t_key_mode              r_key_mode   [KEYS];
    t_key_mode              n_key_mode   [KEYS];
    logic [TIME_BITS-1:0]   r_hold_timer [KEYS];
    logic [TIME_BITS-1:0]   n_hold_timer [KEYS];
    logic [TIME_BITS-1:0]   r_gap_timer  [KEYS];
    logic [TIME_BITS-1:0]   n_gap_timer  [KEYS];
    logic [KEYS-1:0]        r_flag_press, n_flag_press;
    logic [KEYS-1:0]        r_flag_hold,  n_flag_hold;
    logic [KEYS-1:0]        r_flag_multi, n_flag_multi;

    // Threshold comparisons on the updated timers
    logic [KEYS-1:0]        c_hold_gt_press;
    logic [KEYS-1:0]        c_hold_gt_hold;
    logic [KEYS-1:0]        c_gap_lt_interval;

    // Output register and skid stage
    logic                   r_out_valid;
    logic [KEYS-1:0]        r_out_press, r_out_hold, r_out_multi;
    logic                   r_skid_valid;
    logic [KEYS-1:0]        r_skid_press, r_skid_hold, r_skid_multi;

    logic                   in_accept;
    logic                   out_take;

    // Timer add that sticks at the all-ones value.
    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [STEP_BITS-1:0] b);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, a} + (TIME_BITS + 1)'(b);
        return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
    endfunction

    // Handshakes: the input stalls while the skid stage is occupied or reset is held.
    assign o_stall     = r_skid_valid || !i_rst_n;
    assign in_accept   = i_valid && !o_stall;
    assign out_take    = r_out_valid && !i_stall;
    assign o_cfg_ready = i_rst_n;

    assign o_valid       = r_out_valid;
    assign o_press_flags = r_out_press;
    assign o_hold_flags  = r_out_hold;
    assign o_multi_flags = r_out_multi;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_step       <= TICK_STEP_RESET;
            r_press_thresh    <= PRESS_THRESH_RESET;
            r_hold_thresh     <= HOLD_THRESH_RESET;
            r_interval_thresh <= INTERVAL_THRESH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_TICK_STEP:       r_tick_step       <= i_cfg_data[STEP_BITS-1:0];
                REG_PRESS_THRESH:    r_press_thresh    <= i_cfg_data;
                REG_HOLD_THRESH:     r_hold_thresh     <= i_cfg_data;
                REG_INTERVAL_THRESH: r_interval_thresh <= i_cfg_data;
            endcase
        end
    end

    // Timer update for every key, followed by the threshold compares.
    always_comb begin
        for (int k = 0; k < KEYS; k++) begin
            n_hold_timer[k] = r_hold_timer[k];
            if (!i_keys_pressed[k] && r_key_mode[k] != MODE_DITHER
                    && r_key_mode[k] != MODE_HOLD) begin
                n_hold_timer[k] = '0;
            end
            if (i_keys_pressed[k]) begin
                n_hold_timer[k] = sat_add(r_hold_timer[k], r_tick_step);
            end
            if (r_key_mode[k] == MODE_PRECLICK || r_key_mode[k] == MODE_INCLICK) begin
                n_gap_timer[k] = sat_add(r_gap_timer[k], r_tick_step);
            end else begin
                n_gap_timer[k] = '0;
            end
            c_hold_gt_press[k]   = CMP_BITS'(n_hold_timer[k]) > CMP_BITS'(r_press_thresh);
            c_hold_gt_hold[k]    = CMP_BITS'(n_hold_timer[k]) > CMP_BITS'(r_hold_thresh);
            c_gap_lt_interval[k] = CMP_BITS'(n_gap_timer[k]) < CMP_BITS'(r_interval_thresh);
        end
    end

    // Next mode of each key's machine.
    always_comb begin
        for (int k = 0; k < KEYS; k++) begin
            n_key_mode[k] = r_key_mode[k];
            unique case (r_key_mode[k])
                MODE_DITHER: begin
                    if (c_hold_gt_hold[k]) begin
                        n_key_mode[k] = MODE_HOLD;
                    end else if (!i_keys_pressed[k]) begin
                        n_key_mode[k] = c_hold_gt_press[k] ? MODE_PRECLICK : MODE_RELEASE;
                    end
                end
                MODE_PRECLICK: begin
                    if (!c_gap_lt_interval[k]) begin
                        n_key_mode[k] = MODE_PRESS;
                    end else if (c_hold_gt_press[k]) begin
                        n_key_mode[k] = MODE_MULTI;
                    end
                end
                MODE_INCLICK: begin
                    // A second click that is quick and long enough starts another multi.
                    n_key_mode[k] = (c_gap_lt_interval[k] && c_hold_gt_press[k])
                                    ? MODE_MULTI : MODE_RELEASE;
                end
                MODE_PRESS, MODE_HOLD: begin
                    if (!i_keys_pressed[k]) begin
                        n_key_mode[k] = MODE_RELEASE;
                    end
                end
                MODE_MULTI: begin
                    if (!i_keys_pressed[k]) begin
                        n_key_mode[k] = MODE_INCLICK;
                    end
                end
                default: begin
                    // Release, and any code that reset cannot produce.
                    n_key_mode[k] = i_keys_pressed[k] ? MODE_DITHER : MODE_RELEASE;
                end
            endcase
        end
    end

    // Sticky event flags, cleared whenever a key sits in release.
    always_comb begin
        n_flag_press = r_flag_press;
        n_flag_hold  = r_flag_hold;
        n_flag_multi = r_flag_multi;
        for (int k = 0; k < KEYS; k++) begin
            unique case (r_key_mode[k])
                MODE_DITHER, MODE_PRECLICK, MODE_MULTI: begin
                end
                MODE_INCLICK: begin
                    if (!(c_gap_lt_interval[k] && c_hold_gt_press[k])) begin
                        n_flag_multi[k] = 1'b1;
                    end
                end
                MODE_PRESS: begin
                    n_flag_press[k] = 1'b1;
                end
                MODE_HOLD: begin
                    if (!i_keys_pressed[k]) begin
                        n_flag_hold[k] = 1'b1;
                    end
                end
                default: begin
                    n_flag_press[k] = 1'b0;
                    n_flag_hold[k]  = 1'b0;
                    n_flag_multi[k] = 1'b0;
                end
            endcase
        end
    end

    // Key state advances once per accepted scan beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEYS; k++) begin
                r_key_mode[k]   <= MODE_RELEASE;
                r_hold_timer[k] <= '0;
                r_gap_timer[k]  <= '0;
            end
            r_flag_press <= '0;
            r_flag_hold  <= '0;
            r_flag_multi <= '0;
        end else if (in_accept) begin
            for (int k = 0; k < KEYS; k++) begin
                r_key_mode[k]   <= n_key_mode[k];
                r_hold_timer[k] <= n_hold_timer[k];
                r_gap_timer[k]  <= n_gap_timer[k];
            end
            r_flag_press <= n_flag_press;
            r_flag_hold  <= n_flag_hold;
            r_flag_multi <= n_flag_multi;
        end
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload moves with the valid bits above.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_press <= r_skid_press;
                r_out_hold  <= r_skid_hold;
                r_out_multi <= r_skid_multi;
            end
        end else if (in_accept) begin
            if (!r_out_valid || out_take) begin
                r_out_press <= n_flag_press;
                r_out_hold  <= n_flag_hold;
                r_out_multi <= n_flag_multi;
            end else begin
                r_skid_press <= n_flag_press;
                r_skid_hold  <= n_flag_hold;
                r_skid_multi <= n_flag_multi;
            end
        end
    end

endmodule

@@ hdl/kchd_checker.sv @@
// Port-level checks for the key click / hold / multi-click detector.
// Holds the checker module and its bind to the top level. Depends on kchd_pkg.
module kchd_checker
    import kchd_pkg::*;
#(
    parameter int KEYS = KEYS_DEFAULT
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input logic [KEYS-1:0] o_press_flags,
    input logic [KEYS-1:0] o_hold_flags,
    input logic [KEYS-1:0] o_multi_flags
);

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_valid && i_stall)
            |-> o_valid && $stable(o_press_flags) && $stable(o_hold_flags)
                && $stable(o_multi_flags))
        else $error("result beat changed while stalled");

    // A beat taken while the output is empty shows up in the next cycle.
    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_valid && !o_stall && !o_valid) |-> o_valid)
        else $error("accepted beat did not reach the output");

    // No result appears without a scan beat behind it.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(o_valid) && !$past(i_valid && !o_stall) |-> !o_valid)
        else $error("result beat without an accepted scan beat");

    // The input stalls only once a result has been held back.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stalled without a blocked result");

    // A key reports at most one kind of event at a time.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_press_flags & o_hold_flags) == '0)
                 && ((o_press_flags & o_multi_flags) == '0)
                 && ((o_hold_flags & o_multi_flags) == '0))
        else $error("key flagged with more than one event");

endmodule

bind key_click_hold_multi_detector_unit kchd_checker #(
    .KEYS (KEYS)
) u_kchd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_press_flags (o_press_flags),
    .o_hold_flags  (o_hold_flags),
    .o_multi_flags (o_multi_flags)
);

@@ verif/kchd_flag_checker.sv @@
`timescale 1ns / 100ps
// Flag checker for the key click / hold / multi-click detector.
// It watches the scan, flag and register channels, predicts each flag beat and compares.
// Depends on kchd_pkg.
module kchd_flag_checker
    import kchd_pkg::*;
#(
    parameter int KEYS      = KEYS_DEFAULT,
    parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_scan_valid,
    input  logic                      i_scan_stall,
    input  logic [KEYS-1:0]           i_keys_pressed,
    input  logic                      i_flag_valid,
    input  logic                      i_flag_stall,
    input  logic [KEYS-1:0]           i_press_flags,
    input  logic [KEYS-1:0]           i_hold_flags,
    input  logic [KEYS-1:0]           i_multi_flags,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                        o_fail_count,
    output int                        o_flags_due
);

    // Bit positions of the sticky event flags of one key.
    localparam int EV_PRESS = 0;
    localparam int EV_HOLD  = 1;
    localparam int EV_MULTI = 2;

    typedef struct packed {
        logic [KEYS-1:0] press;
        logic [KEYS-1:0] hold;
        logic [KEYS-1:0] multi;
    } t_flag_beat;

    t_key_mode               mode_q         [KEYS];
    logic [TIME_BITS-1:0]    hold_time_q    [KEYS];
    logic [TIME_BITS-1:0]    gap_time_q     [KEYS];
    logic [2:0]              events_q       [KEYS];
    logic [STEP_BITS-1:0]    step_q;
    logic [THRESH_BITS-1:0]  press_thr_q;
    logic [THRESH_BITS-1:0]  hold_thr_q;
    logic [THRESH_BITS-1:0]  interval_thr_q;
    t_flag_beat              flags_due_q    [$];
    t_flag_beat              next_beat;

    initial o_fail_count = 0;

    // Timers advance by the step and stick at their maximum.
    function automatic logic [TIME_BITS-1:0] timer_add(input logic [TIME_BITS-1:0] base,
                                                       input logic [STEP_BITS-1:0] incr);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, base} + (TIME_BITS + 1)'(incr);
        if (sum[TIME_BITS]) return '1;
        return sum[TIME_BITS-1:0];
    endfunction

    // One scan tick over all keys; returns the flags seen after the tick.
    task automatic scan_keys(input logic [KEYS-1:0] keys, output t_flag_beat beat);
        t_key_mode            m;
        logic                 p;
        logic [TIME_BITS-1:0] h;
        logic [TIME_BITS-1:0] g;
        beat = '0;
        for (int k = 0; k < KEYS; k++) begin
            p = keys[k];
            m = mode_q[k];
            if (!p && m != MODE_DITHER && m != MODE_HOLD) hold_time_q[k] = '0;
            if (p) hold_time_q[k] = timer_add(hold_time_q[k], step_q);
            if (m == MODE_PRECLICK || m == MODE_INCLICK) begin
                gap_time_q[k] = timer_add(gap_time_q[k], step_q);
            end else begin
                gap_time_q[k] = '0;
            end
            h = hold_time_q[k];
            g = gap_time_q[k];

            case (m)
                MODE_DITHER: begin
                    if (h > hold_thr_q) mode_q[k] = MODE_HOLD;
                    else if (!p) mode_q[k] = (h > press_thr_q) ? MODE_PRECLICK : MODE_RELEASE;
                end
                MODE_PRECLICK: begin
                    if (g < interval_thr_q) begin
                        if (h > press_thr_q) mode_q[k] = MODE_MULTI;
                    end else begin
                        mode_q[k] = MODE_PRESS;
                    end
                end
                // A second press that is not confirmed still ends the multi-click.
                MODE_INCLICK: begin
                    if (g < interval_thr_q && h > press_thr_q) begin
                        mode_q[k] = MODE_MULTI;
                    end else begin
                        events_q[k][EV_MULTI] = 1'b1;
                        mode_q[k] = MODE_RELEASE;
                    end
                end
                MODE_PRESS: begin
                    events_q[k][EV_PRESS] = 1'b1;
                    if (!p) mode_q[k] = MODE_RELEASE;
                end
                MODE_HOLD: begin
                    if (!p) begin
                        events_q[k][EV_HOLD] = 1'b1;
                        mode_q[k] = MODE_RELEASE;
                    end
                end
                MODE_MULTI: begin
                    if (!p) mode_q[k] = MODE_INCLICK;
                end
                default: begin
                    events_q[k] = '0;
                    mode_q[k] = p ? MODE_DITHER : MODE_RELEASE;
                end
            endcase

            beat.press[k] = events_q[k][EV_PRESS];
            beat.hold[k]  = events_q[k][EV_HOLD];
            beat.multi[k] = events_q[k][EV_MULTI];
        end
    endtask

    task automatic report_field(input string field, input logic [KEYS-1:0] want,
                                input logic [KEYS-1:0] got);
        if (want !== got) begin
            $display("%0t: %s flags mismatch: expected %h, actual %h", $time, field, want, got);
            o_fail_count++;
        end
    endtask

    // Flag beats are checked before this edge's scan beat is predicted, since a
    // scan beat cannot show its flags at the edge that accepts it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEYS; k++) begin
                mode_q[k]      = MODE_RELEASE;
                hold_time_q[k] = '0;
                gap_time_q[k]  = '0;
                events_q[k]    = '0;
            end
            step_q         = TICK_STEP_RESET;
            press_thr_q    = PRESS_THRESH_RESET;
            hold_thr_q     = HOLD_THRESH_RESET;
            interval_thr_q = INTERVAL_THRESH_RESET;
            flags_due_q.delete();
        end else begin
            if (i_flag_valid && !i_flag_stall) begin
                if (flags_due_q.size() == 0) begin
                    $display("%0t: unexpected flag beat: press %h, hold %h, multi %h",
                             $time, i_press_flags, i_hold_flags, i_multi_flags);
                    o_fail_count++;
                end else begin
                    next_beat = flags_due_q.pop_front();
                    report_field("press", next_beat.press, i_press_flags);
                    report_field("hold", next_beat.hold, i_hold_flags);
                    report_field("multi", next_beat.multi, i_multi_flags);
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_TICK_STEP:       step_q         = i_cfg_data[STEP_BITS-1:0];
                    REG_PRESS_THRESH:    press_thr_q    = i_cfg_data[THRESH_BITS-1:0];
                    REG_HOLD_THRESH:     hold_thr_q     = i_cfg_data[THRESH_BITS-1:0];
                    REG_INTERVAL_THRESH: interval_thr_q = i_cfg_data[THRESH_BITS-1:0];
                    default: ;
                endcase
            end

            if (i_scan_valid && !i_scan_stall) begin
                scan_keys(i_keys_pressed, next_beat);
                flags_due_q.push_back(next_beat);
            end
        end
        o_flags_due = flags_due_q.size();
    end

endmodule

@@ verif/tb_key_click_hold_multi_detector_unit.sv @@
`timescale 1ns / 100ps
// Testbench top for the key click / hold / multi-click detector: drives scan beats
// and register writes, applies back-pressure and gives the verdict.
// Depends on kchd_pkg, key_click_hold_multi_detector_unit and kchd_flag_checker.
module tb_key_click_hold_multi_detector_unit;
    import kchd_pkg::*;

    localparam int KEYS         = KEYS_DEFAULT;
    localparam int TIME_BITS    = TIME_BITS_DEFAULT;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 200;
    localparam int RUN_CAP      = 300;
    localparam int LONG_STALL   = 80;
    localparam int DRAIN_CYCLES = 5;

    // Corner values of the key vector, then a click that lingers in pre-click,
    // becomes a multi-click and ends from the in-click state.
    localparam logic [KEYS-1:0] CORNER_SCANS [10] = '{4'h0, 4'hf, 4'h0, 4'h1, 4'h2,
                                                      4'h4, 4'h8, 4'h5, 4'ha, 4'hf};
    localparam logic [KEYS-1:0] CLICK_SCANS  [8]  = '{4'h9, 4'h9, 4'h8, 4'h9, 4'h9,
                                                      4'h0, 4'h0, 4'h0};

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_valid        = 1'b0;
    logic                      o_stall;
    logic [KEYS-1:0]           i_keys_pressed = '0;
    logic                      o_valid;
    logic                      i_stall        = 1'b0;
    logic [KEYS-1:0]           o_press_flags;
    logic [KEYS-1:0]           o_hold_flags;
    logic [KEYS-1:0]           o_multi_flags;
    logic                      i_cfg_valid    = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data     = '0;

    int fail_count;
    int flags_due;

    // Traffic shaping shared between the sender and the receiver.
    bit send_gaps      = 1'b1;
    bit recv_gaps      = 1'b1;
    bit long_stall_req = 1'b0;

    // Register values in force, used to scale the press and release runs.
    int cur_step     = int'(TICK_STEP_RESET);
    int cur_press    = int'(PRESS_THRESH_RESET);
    int cur_hold     = int'(HOLD_THRESH_RESET);
    int cur_interval = int'(INTERVAL_THRESH_RESET);

    key_click_hold_multi_detector_unit #(
        .KEYS      (KEYS),
        .TIME_BITS (TIME_BITS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_keys_pressed (i_keys_pressed),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_press_flags  (o_press_flags),
        .o_hold_flags   (o_hold_flags),
        .o_multi_flags  (o_multi_flags),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    kchd_flag_checker #(
        .KEYS      (KEYS),
        .TIME_BITS (TIME_BITS)
    ) u_flag_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_scan_valid   (i_valid),
        .i_scan_stall   (o_stall),
        .i_keys_pressed (i_keys_pressed),
        .i_flag_valid   (o_valid),
        .i_flag_stall   (i_stall),
        .i_press_flags  (o_press_flags),
        .i_hold_flags   (o_hold_flags),
        .i_multi_flags  (o_multi_flags),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_flags_due    (flags_due)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one scan beat and hold it until it is taken.
    task automatic send_scan(input logic [KEYS-1:0] keys);
        int n;
        @(negedge i_clk);
        n = send_gaps ? pick_gap() : 0;
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_keys_pressed <= keys;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Stop offering and wait until every flag beat has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (flags_due != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // The step register only uses its low bits; the upper data bits are noise.
    task automatic set_thresholds(input int step, input int press, input int hold,
                                  input int interval);
        wait_drained();
        write_reg(REG_TICK_STEP, {8'($urandom), 8'(step)});
        write_reg(REG_PRESS_THRESH, 16'(press));
        write_reg(REG_HOLD_THRESH, 16'(hold));
        write_reg(REG_INTERVAL_THRESH, 16'(interval));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_step     = step;
        cur_press    = press;
        cur_hold     = hold;
        cur_interval = interval;
    endtask

    // Receiver: random stalls, with one long hold-off on request.
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                n = LONG_STALL;
            end else begin
                n = recv_gaps ? pick_gap() : 0;
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_stall <= 1'b0;
        end
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // Stimulus: directed corners, then phases of per-key press and release runs
    // scaled to the thresholds in force, with some noise mixed in.
    initial begin
        logic [KEYS-1:0] scan;
        logic [KEYS-1:0] key_level;
        int              run_left [KEYS];
        int              r;
        int              run;
        int              unit;
        int              press_t;
        int              hold_t;
        int              gap_t;
        int              pick;

        key_level = '0;
        for (int k = 0; k < KEYS; k++) run_left[k] = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (CORNER_SCANS[i]) send_scan(CORNER_SCANS[i]);
        set_thresholds(255, 300, 65535, 65535);
        foreach (CLICK_SCANS[i]) send_scan(CLICK_SCANS[i]);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: set_thresholds(0, 0, 0, 0);
                1: set_thresholds(255, 0, 0, 0);
                2: set_thresholds(255, 65535, 65535, 65535);
                3: set_thresholds(int'(TICK_STEP_RESET), int'(PRESS_THRESH_RESET),
                                  int'(HOLD_THRESH_RESET), int'(INTERVAL_THRESH_RESET));
                7: set_thresholds($urandom_range(0, 255), $urandom_range(0, 65535),
                                  $urandom_range(0, 65535), $urandom_range(0, 65535));
                default: begin
                    pick = $urandom_range(0, 40);
                    set_thresholds($urandom_range(1, 8), pick, pick + $urandom_range(0, 120),
                                   $urandom_range(0, 80));
                end
            endcase

            // Phase 3 lets the block fill up behind a long stall; phase 5 runs flat out.
            send_gaps = (ph != 3 && ph != 5);
            recv_gaps = (ph != 5);
            if (ph == 3) long_stall_req = 1'b1;

            unit    = (cur_step == 0) ? 1 : cur_step;
            press_t = (cur_press / unit > RUN_CAP) ? RUN_CAP : cur_press / unit;
            hold_t  = (cur_hold / unit > RUN_CAP) ? RUN_CAP : cur_hold / unit;
            gap_t   = (cur_interval / unit > RUN_CAP) ? RUN_CAP : cur_interval / unit;

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                for (int k = 0; k < KEYS; k++) begin
                    if (run_left[k] == 0) begin
                        key_level[k] = ~key_level[k];
                        r = $urandom_range(0, 99);
                        if (r < 25) run = $urandom_range(1, press_t + 2);
                        else if (r < 45) run = press_t + $urandom_range(0, 2);
                        else if (r < 65) run = $urandom_range(1, gap_t + 2);
                        else if (r < 75) run = gap_t + $urandom_range(0, 2);
                        else if (r < 90) run = hold_t + $urandom_range(0, 3);
                        else run = $urandom_range(1, 2);
                        run_left[k] = (run < 1) ? 1 : ((run > RUN_CAP) ? RUN_CAP : run);
                    end
                    run_left[k]--;
                end
                scan = key_level;
                r = $urandom_range(0, 99);
                if (r < 8) scan = scan ^ KEYS'($urandom);
                else if (r < 11) scan = KEYS'($urandom);
                send_scan(scan);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
